// ===== hdl/amd_pkg.sv =====
// shared types, widths and constants of the accelerometer motion debouncer
package amd_pkg;

  // field widths
  localparam int unsigned RawW    = 16;
  localparam int unsigned ScaledW = 20;
  localparam int unsigned DiffW   = ScaledW + 1;
  localparam int unsigned RangeW  = 2;
  localparam int unsigned ThreshW = 19;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegRangeSelect   = 2'd0;
  localparam logic [1:0] RegChangeThresh  = 2'd1;
  localparam logic [1:0] RegDebounceThr   = 2'd2;
  localparam logic [1:0] RegCountHeadroom = 2'd3;

  // register reset values
  localparam logic [RangeW-1:0]  RangeReset    = 2'd0;
  localparam logic [ThreshW-1:0] ChangeReset   = 19'd167;
  localparam logic [ByteW-1:0]   DebounceReset = 8'd30;
  localparam logic [ByteW-1:0]   HeadroomReset = 8'd70;

  // debounce settings handed to the counter
  typedef struct packed {
    logic [ByteW-1:0] debounce_thresh;
    logic [ByteW-1:0] count_headroom;
  } cnt_cfg_t;

  // counter outcome for one item
  typedef struct packed {
    logic              active;
    logic [CountW-1:0] count;
  } cnt_res_t;

endpackage

// ===== hdl/accel_motion_debouncer_core.sv =====
// top level of the accelerometer motion debouncer: registers, stream stages and state
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/tready        tdata[47:0]  x, y, z samples
// m_axis    out        m_axis_tvalid/tready        tdata[15:0]  on, motion, confidence
// apb       in         psel/penable/pwrite/pready  4 registers at 0x0..0xc
//
// an item passes input register -> result register; one item per cycle while the
// result side is not stalled; the rate is set by the single state update of the
// count and last samples per item
// reset clears stored samples, count, registers to their defaults, both stages empty
// a stalled result holds while the input register still takes one more item
module accel_motion_debouncer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input samples
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  input  logic [47:0]                  s_axis_tdata,
  // results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] sensor_on, [1] motion_seen, [10:2] confidence, [15:11] zero
  output logic [15:0]                  m_axis_tdata,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [amd_pkg::AddrW-1:0]    paddr,
  input  logic [amd_pkg::DataW-1:0]    pwdata,
  output logic [amd_pkg::DataW-1:0]    prdata,
  output logic                         pready
);
  import amd_pkg::*;

  logic [RangeW-1:0]  range_q;
  logic [ThreshW-1:0] change_q;
  cnt_cfg_t           cnt_cfg_q;
  logic               cfg_we;

  logic               in_valid_q, in_valid_d;
  logic [47:0]        in_data_q;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_data_q;
  logic               s_accept, m_accept, advance;

  logic signed [ScaledW-1:0] last_x_q, last_y_q, last_z_q;
  logic signed [ScaledW-1:0] sx, sy, sz;
  logic               mx, my, mz, motion;
  cnt_res_t           cnt_res;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q                   <= RangeReset;
      change_q                  <= ChangeReset;
      cnt_cfg_q.debounce_thresh <= DebounceReset;
      cnt_cfg_q.count_headroom  <= HeadroomReset;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegRangeSelect:   range_q                   <= pwdata[RangeW-1:0];
        RegChangeThresh:  change_q                  <= pwdata[ThreshW-1:0];
        RegDebounceThr:   cnt_cfg_q.debounce_thresh <= pwdata[ByteW-1:0];
        RegCountHeadroom: cnt_cfg_q.count_headroom  <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      RegRangeSelect:   prdata = DataW'(range_q);
      RegChangeThresh:  prdata = DataW'(change_q);
      RegDebounceThr:   prdata = DataW'(cnt_cfg_q.debounce_thresh);
      RegCountHeadroom: prdata = DataW'(cnt_cfg_q.count_headroom);
      default:          prdata = '0;
    endcase
  end

  // stage handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)       out_valid_d = 1'b1;
    else if (m_accept) out_valid_d = 1'b0;
  end

  // per-axis scaling and change detection
  amd_axis u_axis_x (
    .raw_i(in_data_q[15:0]), .last_i(last_x_q), .range_i(range_q),
    .thresh_i(change_q), .scaled_o(sx), .moved_o(mx)
  );
  amd_axis u_axis_y (
    .raw_i(in_data_q[31:16]), .last_i(last_y_q), .range_i(range_q),
    .thresh_i(change_q), .scaled_o(sy), .moved_o(my)
  );
  amd_axis u_axis_z (
    .raw_i(in_data_q[47:32]), .last_i(last_z_q), .range_i(range_q),
    .thresh_i(change_q), .scaled_o(sz), .moved_o(mz)
  );

  assign motion = mx || my || mz;

  // debounce count
  amd_count u_count (
    .clk_i(clk_i), .rst_ni(rst_ni), .update_i(advance),
    .motion_i(motion), .cfg_i(cnt_cfg_q), .res_o(cnt_res)
  );

  // stage valid bits and stored samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_z_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        last_x_q <= sx;
        last_y_q <= sy;
        last_z_q <= sz;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) in_data_q <= s_axis_tdata;
    if (advance)  out_data_q <= {5'd0, cnt_res.count, motion, cnt_res.active};
  end

  // a result appears only from a held item
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without an input item");

endmodule

// ===== hdl/amd_axis.sv =====
// per-axis range scaling and change detection against the stored sample
module amd_axis (
  input  logic signed [amd_pkg::RawW-1:0]    raw_i,
  input  logic signed [amd_pkg::ScaledW-1:0] last_i,
  input  logic        [amd_pkg::RangeW-1:0]  range_i,
  input  logic        [amd_pkg::ThreshW-1:0] thresh_i,
  output logic signed [amd_pkg::ScaledW-1:0] scaled_o,
  output logic                               moved_o
);
  import amd_pkg::*;

  logic signed [ScaledW-1:0] ext;
  logic signed [DiffW-1:0]   diff;
  logic        [DiffW-1:0]   mag;

  // sign extend and scale by 2^range into 1/16384 g
  assign ext      = ScaledW'(raw_i);
  assign scaled_o = ext <<< range_i;

  // absolute change, compared unsigned with the threshold
  assign diff    = DiffW'(scaled_o) - DiffW'(last_i);
  assign mag     = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign moved_o = (mag >= DiffW'(thresh_i));

endmodule

// ===== hdl/amd_count.sv =====
// saturating up/down debounce count and mode decision
module amd_count (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          update_i,
  input  logic                          motion_i,
  input  amd_pkg::cnt_cfg_t             cfg_i,
  output amd_pkg::cnt_res_t             res_o
);
  import amd_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] ceiling;

  assign ceiling = CountW'(cfg_i.debounce_thresh) + CountW'(cfg_i.count_headroom);

  // next count: up to the ceiling on motion, down to zero otherwise
  always_comb begin
    cnt_d = cnt_q;
    if (motion_i) begin
      if (cnt_q < ceiling) cnt_d = cnt_q + 1'b1;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // mode uses the count from before the update
  assign res_o.active = (cnt_q >= CountW'(cfg_i.debounce_thresh));
  assign res_o.count  = cnt_d;

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (update_i) begin
      cnt_q <= cnt_d;
    end
  end

  // count moves by at most one per item
  a_step_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    update_i |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
                 (cnt_q == $past(cnt_q) - 1'b1))
    else $error("debounce count jumped by more than one");

  // count holds between items
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !update_i |=> $stable(cnt_q))
    else $error("debounce count changed without an item");

  // motion never lowers the count
  a_motion_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && motion_i) |=> (cnt_q >= $past(cnt_q)))
    else $error("debounce count fell on motion");

endmodule

// ===== sim/accel_motion_debouncer_core_tb.sv =====
// self-checking testbench for the accelerometer motion debouncer core
`timescale 1ns / 100ps

module accel_motion_debouncer_core_tb;
  import amd_pkg::*;

  // one expected result item
  typedef struct packed {
    logic              sensor_on;
    logic              motion_seen;
    logic [CountW-1:0] confidence;
  } debounce_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  logic [47:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] sensor_on, [1] motion_seen, [10:2] confidence, [15:11] zero
  logic [15:0]       m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // predictor copy of the registers and the state
  logic [RangeW-1:0]         range_cfg = RangeReset;
  logic [ThreshW-1:0]        change_cfg = ChangeReset;
  logic [ByteW-1:0]          debounce_cfg = DebounceReset;
  logic [ByteW-1:0]          headroom_cfg = HeadroomReset;
  logic signed [ScaledW-1:0] last_scaled [3] = '{default: '0};
  logic [CountW-1:0]         confidence_count = '0;

  logic [47:0]      sample_queue [$];
  debounce_result_t expected_results [$];
  int unsigned      error_count = 0;

  // pacing controls
  bit          idle_on = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  // sample generator state
  logic [15:0] gen_axis [3] = '{default: '0};
  int unsigned gen_style = 0;

  accel_motion_debouncer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // scale, compare with last sample and update the saturating count
  function automatic void predict_result(logic [47:0] sample);
    logic signed [ScaledW-1:0] scaled [3];
    int                        raw_val;
    int                        diff;
    bit                        moved;
    logic [CountW-1:0]         ceiling;
    debounce_result_t          res;
    moved = 1'b0;
    for (int a = 0; a < 3; a++) begin
      raw_val = $signed(sample[16*a +: 16]);
      raw_val = raw_val * (1 << range_cfg);
      scaled[a] = raw_val[ScaledW-1:0];
      diff = int'(scaled[a]) - int'(last_scaled[a]);
      if (diff < 0) diff = -diff;
      if (diff >= int'(change_cfg)) moved = 1'b1;
      last_scaled[a] = scaled[a];
    end
    ceiling = CountW'(debounce_cfg) + CountW'(headroom_cfg);
    res.sensor_on = (confidence_count >= CountW'(debounce_cfg));
    if (moved) begin
      if (confidence_count < ceiling) confidence_count = confidence_count + 1'b1;
    end else if (confidence_count != '0) begin
      confidence_count = confidence_count - 1'b1;
    end
    res.motion_seen = moved;
    res.confidence = confidence_count;
    expected_results.push_back(res);
  endfunction

  // sample driver: offers queued items, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_result(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          s_axis_tdata <= sample_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 5);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each item and paces tready
  always @(posedge clk_i or negedge rst_ni) begin
    debounce_result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
      sink_hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata[0] !== exp_res.sensor_on) begin
            $error("sensor_on: expected %0d, got %0d", exp_res.sensor_on, m_axis_tdata[0]);
            error_count++;
          end
          if (m_axis_tdata[1] !== exp_res.motion_seen) begin
            $error("motion_seen: expected %0d, got %0d", exp_res.motion_seen,
                   m_axis_tdata[1]);
            error_count++;
          end
          if (m_axis_tdata[10:2] !== exp_res.confidence) begin
            $error("confidence: expected %0d, got %0d", exp_res.confidence,
                   m_axis_tdata[10:2]);
            error_count++;
          end
        end
      end
      // long hold-off on request, else short random gaps
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        sink_hold_left = 300;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 5);
      end
    end
  end

  // apb write, then read back and compare with the masked value
  task automatic write_register(logic [1:0] reg_idx, logic [DataW-1:0] value);
    logic [DataW-1:0] stored;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (reg_idx)
      RegRangeSelect: begin
        range_cfg = value[RangeW-1:0];
        stored = DataW'(range_cfg);
      end
      RegChangeThresh: begin
        change_cfg = value[ThreshW-1:0];
        stored = DataW'(change_cfg);
      end
      RegDebounceThr: begin
        debounce_cfg = value[ByteW-1:0];
        stored = DataW'(debounce_cfg);
      end
      default: begin
        headroom_cfg = value[ByteW-1:0];
        stored = DataW'(headroom_cfg);
      end
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      $error("prdata at %h: expected %h, got %h", {reg_idx, 2'b00}, stored, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every queued item has been sent and every result received
  task automatic wait_drained();
    while (sample_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // all four registers, junk above each register width
  task automatic configure(int unsigned rng, int unsigned thr, int unsigned dbc,
                           int unsigned hdr);
    wait_drained();
    write_register(RegRangeSelect, DataW'(rng) | ($urandom() << RangeW));
    write_register(RegChangeThresh, DataW'(thr) | ($urandom() << ThreshW));
    write_register(RegDebounceThr, DataW'(dbc) | ($urandom() << ByteW));
    write_register(RegCountHeadroom, DataW'(hdr) | ($urandom() << ByteW));
    @(negedge clk_i);
  endtask

  task automatic push_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    sample_queue.push_back({z, y, x});
    gen_axis[0] = x;
    gen_axis[1] = y;
    gen_axis[2] = z;
  endtask

  // runs of still, near-threshold, moving and noisy samples
  task automatic queue_samples(int unsigned n);
    int unsigned step;
    int          d;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) gen_style = $urandom_range(0, 3);
      step = change_cfg >> range_cfg;
      for (int a = 0; a < 3; a++) begin
        case (gen_style)
          0:       d = $urandom_range(0, step / 2);
          1:       d = int'(step) + int'($urandom_range(0, 3)) - 2;
          2:       d = int'(step) + int'($urandom_range(0, 4096));
          default: d = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 1)) d = -d;
        gen_axis[a] = gen_axis[a] + d[15:0];
      end
      sample_queue.push_back({gen_axis[2], gen_axis[1], gen_axis[0]});
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: first sample against zero, threshold edges, extremes
    push_sample(16'd0, 16'd0, 16'd0);
    push_sample(16'd167, 16'd0, 16'd0);
    push_sample(16'd1, 16'd0, 16'd0);
    push_sample(16'd1, 16'd167, 16'd0);
    push_sample(16'd1, 16'd167, -16'sd167);
    push_sample(16'h7fff, 16'h8000, 16'h0000);
    push_sample(16'h8000, 16'h7fff, 16'h7fff);
    push_sample(16'h8000, 16'h7fff, 16'h7fff);
    push_sample(16'h5555, 16'haaaa, 16'h5555);
    push_sample(16'haaaa, 16'h5555, 16'haaaa);

    // range change against stored values, then climb to the ceiling
    configure(3, 0, 20, 40);
    push_sample(16'haaaa, 16'h5555, 16'haaaa);
    queue_samples(69);

    // ceiling lowered below the count: motion holds it
    configure(1, 0, 5, 5);
    queue_samples(6);

    // no motion possible: count falls
    configure(2, 524287, 5, 5);
    queue_samples(15);

    // random settings, one phase under a long receiver hold-off
    for (int p = 0; p < 4; p++) begin
      if (p == 3) configure($urandom_range(0, 3), $urandom_range(0, 3000), 0, 0);
      else configure($urandom_range(0, 3), $urandom_range(0, 4000),
                     $urandom_range(0, 12), $urandom_range(0, 20));
      if (p == 1) hold_req++;
      queue_samples(p == 1 ? 100 : 30);
    end

    // widest ceiling, count saturates at its top
    configure($urandom_range(0, 3), 0, 255, 255);
    queue_samples(515);

    // last part without idling
    configure(0, $urandom_range(100, 2000), 10, 10);
    idle_on = 1'b0;
    queue_samples(60);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** accel_motion_debouncer_core: PASSED **");
    end else begin
      $display("** accel_motion_debouncer_core: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("** accel_motion_debouncer_core: FAILED **");
    $finish;
  end

endmodule
